/* rtl/fpm_pkg.sv */
// ----------------------------------------------------------------------------
// fpm_pkg
// Shared types and constants for the first pattern match finder.
// ----------------------------------------------------------------------------
package fpm_pkg;

  localparam int unsigned CFG_W     = 6;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned IDX_W     = 5;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned POS_W     = 13;
  localparam int unsigned S_TDATA_W = 16;
  localparam int unsigned M_TDATA_W = 16;
  localparam int unsigned M_TUSER_W = 2;

  // Item kinds carried on the input tuser
  typedef enum logic [MODE_W-1:0] {
    MODE_PATTERN = 2'd0,
    MODE_TEXT    = 2'd1,
    MODE_END     = 2'd2
  } mode_e;

  // Line control shared by every cell of the row
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

/* rtl/fpm_cell.sv */
// ----------------------------------------------------------------------------
// fpm_cell
// One cell of the match row: one pattern byte, one text window byte and a
// byte comparator. Window bytes move one cell down per accepted text byte within the line limit.
// ----------------------------------------------------------------------------
module fpm_cell
  import fpm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cell_ctrl_t        ctrl_i,
  input  logic              pat_we_i,
  input  logic [BYTE_W-1:0] pat_byte_i,
  input  logic [BYTE_W-1:0] shift_byte_i,
  input  logic [BYTE_W-1:0] probe_byte_i,
  input  logic              in_use_i,
  output logic [BYTE_W-1:0] window_o,
  output logic              hit_o
);

  logic [BYTE_W-1:0] window_q;
  logic [BYTE_W-1:0] pattern_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
    end else if (ctrl_i.clear) begin
      window_q <= '0;
    end else if (ctrl_i.shift) begin
      window_q <= shift_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pat_we_i) begin
      pattern_q <= pat_byte_i;
    end
  end

  assign window_o = window_q;
  // a cell beyond the pattern length never blocks a match
  assign hit_o    = !in_use_i || (pattern_q == probe_byte_i);

endmodule

/* rtl/first_pattern_match_finder_top.sv */
// ----------------------------------------------------------------------------
// first_pattern_match_finder_top
// Streaming first-occurrence search of a stored pattern in each text line.
// ----------------------------------------------------------------------------
// Pattern writes and text bytes are always accepted, and a text byte is
// compared against the whole pattern in the cycle it arrives, by a row of
// PATTERN_MAX cells that each hold one pattern byte and one byte of the
// sliding text window. An end-of-line transaction loads the single result
// register; it stalls only while a previous result still sits there
// untaken. No clearing pass runs after reset. The pattern length read from
// its register is clamped to PATTERN_MAX; bytes past LINE_MAX in a line are
// dropped and flagged in that line's result.
module first_pattern_match_finder_top
  import fpm_pkg::*;
#(
  parameter int unsigned PATTERN_MAX = 32,
  parameter int unsigned LINE_MAX    = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,      // pattern_length
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,   // [4:0] pattern_index, [12:5] data_byte
  input  logic [MODE_W-1:0]    s_axis_tuser_i,   // [1:0] mode
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [M_TDATA_W-1:0] m_axis_tdata_o,   // [12:0] match_position
  output logic [M_TUSER_W-1:0] m_axis_tuser_o    // [0] found, [1] too_long
);

  localparam int unsigned LW = $clog2(PATTERN_MAX + 1);
  localparam int unsigned IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int unsigned SW = $clog2(2 * PATTERN_MAX) + 1;
  localparam int unsigned CW = $clog2(LINE_MAX + 1);
  localparam int unsigned MW = ((CW > LW) ? CW : LW) + 1;

  logic [CFG_W-1:0]  cfg_len_q;
  logic [LW-1:0]     len;
  mode_e             mode;
  logic [IDX_W-1:0]  pat_idx;
  logic [BYTE_W-1:0] data_byte;
  logic              s_acc, text_acc, end_acc, room, shift;
  logic [CW-1:0]     count_q, count_nxt;
  logic              match_seen_q, overflow_seen_q;
  logic [CW-1:0]     first_pos_q;
  logic [MW-1:0]     pos_now;
  logic              match_now;
  logic              m_valid_q, found_q, too_long_q;
  logic [POS_W-1:0]  pos_q;
  cell_ctrl_t        ctrl;

  logic [BYTE_W-1:0] win     [PATTERN_MAX];
  logic [BYTE_W-1:0] nxt_win [PATTERN_MAX];
  logic [BYTE_W-1:0] probe   [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] in_use;
  logic [PATTERN_MAX-1:0] hit;
  logic [PATTERN_MAX-1:0] pat_we;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_len_q <= '0;
    end else if (cfg_we_i) begin
      cfg_len_q <= cfg_wdata_i;
    end
  end

  assign len = (MW'(cfg_len_q) > MW'(PATTERN_MAX)) ? LW'(PATTERN_MAX) : LW'(cfg_len_q);

  assign mode      = mode_e'(s_axis_tuser_i);
  assign pat_idx   = s_axis_tdata_i[IDX_W-1:0];
  assign data_byte = s_axis_tdata_i[IDX_W +: BYTE_W];

  assign s_axis_tready_o = (mode != MODE_END) || !m_valid_q || m_axis_tready_i;
  assign s_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign text_acc = s_acc && (mode == MODE_TEXT);
  assign end_acc  = s_acc && (mode == MODE_END);
  assign room     = count_q < CW'(LINE_MAX);
  assign shift    = text_acc && room;

  assign ctrl.shift = shift;
  assign ctrl.clear = end_acc;

  // ---- row of cells ----
  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    logic [SW-1:0] src;

    if (k == PATTERN_MAX - 1) begin : g_tail
      assign nxt_win[k] = data_byte;
    end else begin : g_body
      assign nxt_win[k] = win[k+1];
    end

    // cell k lines up with window slot PATTERN_MAX - len + k after the shift
    assign in_use[k] = SW'(k) < SW'(len);
    assign src       = SW'(PATTERN_MAX) - SW'(len) + SW'(k);
    assign probe[k]  = in_use[k] ? nxt_win[src[IW-1:0]] : '0;
    assign pat_we[k] = s_acc && (mode == MODE_PATTERN) && (32'(pat_idx) == k);

    fpm_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .pat_we_i     (pat_we[k]),
      .pat_byte_i   (data_byte),
      .shift_byte_i (nxt_win[k]),
      .probe_byte_i (probe[k]),
      .in_use_i     (in_use[k]),
      .window_o     (win[k]),
      .hit_o        (hit[k])
    );
  end

  // ---- line tracking ----
  assign count_nxt = count_q + CW'(1);
  assign pos_now   = MW'(count_nxt) - MW'(len) + MW'(1);
  assign match_now = shift && !match_seen_q && (len != '0)
                     && (MW'(count_nxt) >= MW'(len)) && (&hit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q         <= '0;
      match_seen_q    <= 1'b0;
      first_pos_q     <= '0;
      overflow_seen_q <= 1'b0;
    end else if (end_acc) begin
      count_q         <= '0;
      match_seen_q    <= 1'b0;
      first_pos_q     <= '0;
      overflow_seen_q <= 1'b0;
    end else begin
      if (shift) begin
        count_q <= count_nxt;
      end
      if (text_acc && !room) begin
        overflow_seen_q <= 1'b1;
      end
      if (match_now) begin
        match_seen_q <= 1'b1;
        first_pos_q  <= CW'(pos_now);
      end
    end
  end

  // ---- result register ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (end_acc) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (end_acc) begin
      too_long_q <= overflow_seen_q;
      priority if (len == '0) begin
        found_q <= 1'b1;
        pos_q   <= POS_W'(1);
      end else if (match_seen_q) begin
        found_q <= 1'b1;
        pos_q   <= POS_W'(first_pos_q);
      end else begin
        found_q <= 1'b0;
        pos_q   <= '0;
      end
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = M_TDATA_W'(pos_q);
  assign m_axis_tuser_o  = {too_long_q, found_q};

  // ---- assertions ----
  a_result_from_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(end_acc))
    else $error("result appeared without an end-of-line transaction");

  a_notfound_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !found_q) |-> (pos_q == '0))
    else $error("position nonzero on a miss");

  a_pos_in_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    match_seen_q |-> ((first_pos_q != '0) && (first_pos_q <= count_q)))
    else $error("match position outside the line");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(LINE_MAX))
    else $error("line byte count beyond LINE_MAX");

endmodule

/* dv/tb_first_pattern_match_finder_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_pattern_match_finder_top
// Self-checking bench for the streaming first pattern match finder.
// ----------------------------------------------------------------------------
// The bench loads a pattern, sets its length and streams text lines through
// the input stream. It tracks the search in its own model of the pattern
// store and the sliding window, and predicts one result per end of line.
// Each result taken from the output stream is checked field by field.
// Both streams idle at random. The output side also holds off for a long
// stretch so that the block fills up and stalls its input. Pattern lengths
// run from empty to above the store size, and two lines run up to the line
// limit and past it.
// ----------------------------------------------------------------------------
module tb_first_pattern_match_finder_top;
  import fpm_pkg::*;

  localparam int unsigned PAT_MAX       = 32;
  localparam int unsigned LINE_LIMIT    = 4096;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned RANDOM_ITEMS  = 1700;
  localparam int unsigned SHOW_LIMIT    = 10;
  // Kind code with no meaning; the block drops it
  localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
    logic             too_long;
  } line_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [MODE_W-1:0]    s_tuser = MODE_PATTERN;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [M_TUSER_W-1:0] m_tuser;

  // Search state as the bench sees it
  logic [BYTE_W-1:0] sw_pattern [PAT_MAX];
  logic [BYTE_W-1:0] sw_window  [PAT_MAX];
  int unsigned       sw_count;
  logic              sw_hit;
  int unsigned       sw_hit_pos;
  logic              sw_overflow;
  logic [CFG_W-1:0]  sw_len = '0;
  line_result_t      pending_lines [$];

  int unsigned items_sent     = 0;
  int unsigned lines_checked  = 0;
  int unsigned overflow_lines = 0;
  int unsigned error_count    = 0;
  int unsigned mismatch_count = 0;
  int unsigned rx_hold_cycles = 0;
  bit          no_gaps        = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  first_pattern_match_finder_top #(
    .PATTERN_MAX (PAT_MAX),
    .LINE_MAX    (LINE_LIMIT)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  function automatic int unsigned used_len();
    return (sw_len > PAT_MAX) ? PAT_MAX : int'(sw_len);
  endfunction

  function automatic logic [BYTE_W-1:0] rand_byte();
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [BYTE_W-1:0] other_byte(input logic [BYTE_W-1:0] avoid);
    logic [BYTE_W-1:0] b;
    b = rand_byte();
    return (b == avoid) ? ~avoid : b;
  endfunction

  task automatic clear_line_state();
    for (int k = 0; k < PAT_MAX; k++) sw_window[k] = '0;
    sw_count    = 0;
    sw_hit      = 1'b0;
    sw_hit_pos  = 0;
    sw_overflow = 1'b0;
  endtask

  // Advance the search by one accepted transaction
  task automatic track_item(input logic [MODE_W-1:0] mode, input logic [IDX_W-1:0] idx,
                            input logic [BYTE_W-1:0] b);
    int unsigned  len;
    bit           same;
    line_result_t res;
    case (mode)
      MODE_PATTERN: sw_pattern[idx] = b;
      MODE_TEXT: begin
        if (sw_count >= LINE_LIMIT) begin
          sw_overflow = 1'b1;
        end else begin
          for (int k = 0; k < PAT_MAX - 1; k++) sw_window[k] = sw_window[k+1];
          sw_window[PAT_MAX-1] = b;
          sw_count++;
          len = used_len();
          if (!sw_hit && len != 0 && sw_count >= len) begin
            same = 1'b1;
            for (int k = 0; k < len; k++) begin
              if (sw_window[PAT_MAX-len+k] !== sw_pattern[k]) same = 1'b0;
            end
            if (same) begin
              sw_hit     = 1'b1;
              sw_hit_pos = sw_count - len + 1;
            end
          end
        end
      end
      MODE_END: begin
        res.found    = (used_len() == 0) || sw_hit;
        res.position = (used_len() == 0) ? POS_W'(1) : (sw_hit ? POS_W'(sw_hit_pos) : '0);
        res.too_long = sw_overflow;
        pending_lines.push_back(res);
        clear_line_state();
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [IDX_W-1:0] idx,
                           input logic [BYTE_W-1:0] b);
    int unsigned          gap;
    logic [S_TDATA_W-1:0] word;
    gap  = no_gaps ? 0 : $urandom_range(0, 4);
    word = '0;
    word[IDX_W-1:0]      = idx;
    word[IDX_W +: BYTE_W] = b;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    s_tuser  <= mode;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    track_item(mode, idx, b);
    if (mode != MODE_NONE) items_sent++;
    @(negedge clk_i);
  endtask

  task automatic put(input logic [BYTE_W-1:0] b);
    send_item(MODE_TEXT, IDX_W'($urandom_range(0, PAT_MAX - 1)), b);
  endtask

  task automatic end_line();
    send_item(MODE_END, IDX_W'($urandom_range(0, PAT_MAX - 1)), rand_byte());
  endtask

  task automatic write_pat(input int unsigned idx, input logic [BYTE_W-1:0] b);
    send_item(MODE_PATTERN, IDX_W'(idx), b);
  endtask

  // Stop sending and wait until every pending line result has been taken
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_lines.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_length(input logic [CFG_W-1:0] len);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    sw_len     = len;
  endtask

  // Output side: random stalls, or a long hold-off when one is requested
  always begin : rx_ready
    int unsigned stall;
    @(negedge clk_i);
    if (rx_hold_cycles != 0) begin
      stall          = rx_hold_cycles;
      rx_hold_cycles = 0;
    end else begin
      stall = no_gaps ? 0 : $urandom_range(0, 4);
    end
    if (stall != 0) begin
      m_tready <= 1'b0;
      repeat (stall) @(negedge clk_i);
    end
    m_tready <= 1'b1;
    @(posedge clk_i);
    while (!(m_tvalid && m_tready)) @(posedge clk_i);
  end

  task automatic note_mismatch(input string what, input line_result_t want,
                               input line_result_t got);
    error_count++;
    mismatch_count++;
    if (mismatch_count <= SHOW_LIMIT) begin
      $display("%0t: %s: expected found/pos/too_long %0b/%0d/%0b, got %0b/%0d/%0b",
               $realtime, what, want.found, want.position, want.too_long,
               got.found, got.position, got.too_long);
    end
  endtask

  always @(posedge clk_i) begin : check_result
    line_result_t want;
    line_result_t got;
    if (rst_n && m_tvalid && m_tready) begin
      got.found    = m_tuser[0];
      got.position = m_tdata[POS_W-1:0];
      got.too_long = m_tuser[1];
      if (pending_lines.size() == 0) begin
        note_mismatch("result with no line pending", '0, got);
      end else begin
        want = pending_lines.pop_front();
        lines_checked++;
        if (want.too_long) overflow_lines++;
        if (got.found !== want.found || got.position !== want.position ||
            got.too_long !== want.too_long) begin
          note_mismatch("line result mismatch", want, got);
        end
      end
    end
  end

  // Fill the whole store first so no unwritten entry is ever compared
  task automatic test_empty_pattern();
    for (int i = 0; i < PAT_MAX; i++) begin
      write_pat(i, (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : rand_byte());
    end
    end_line();
    put(8'h41);
    put(8'h42);
    end_line();
    set_length('0);
    put(8'hFF);
    end_line();
  endtask

  task automatic test_short_patterns();
    set_length(6'd1);
    write_pat(0, 8'h00);
    put(8'hFF);
    put(8'h00);
    end_line();
    put(8'hFF);
    send_item(MODE_NONE, 5'd31, 8'h00);
    put(8'hFF);
    end_line();
    // Zeroed window must not match a zero pattern longer than the line
    set_length(6'd3);
    for (int i = 0; i < 3; i++) write_pat(i, 8'h00);
    put(8'h00);
    put(8'h00);
    end_line();
    repeat (3) put(8'h00);
    end_line();
    // Pattern writes apply to the following bytes; a seen match is kept
    set_length(6'd2);
    write_pat(0, 8'h5A);
    write_pat(1, 8'h3C);
    put(8'h5A);
    write_pat(1, 8'hC3);
    put(8'hC3);
    write_pat(0, 8'h00);
    put(8'h00);
    end_line();
  endtask

  task automatic test_full_pattern();
    set_length(6'd63);
    repeat (3) put(rand_byte());
    for (int k = 0; k < PAT_MAX; k++) put(sw_pattern[k]);
    end_line();
    for (int k = 0; k < PAT_MAX - 1; k++) put(sw_pattern[k]);
    end_line();
    set_length(6'd32);
    for (int k = 0; k < PAT_MAX; k++) put(sw_pattern[k]);
    end_line();
  endtask

  task automatic test_line_limit();
    set_length(6'd1);
    write_pat(0, 8'hA5);
    // Match on the very last byte that still counts
    for (int i = 0; i < LINE_LIMIT - 1; i++) put(other_byte(8'hA5));
    put(8'hA5);
    end_line();
    // Match would complete one byte past the limit: dropped and flagged
    set_length(6'd4);
    write_pat(1, 8'h5A);
    write_pat(2, 8'hC3);
    write_pat(3, 8'h3C);
    for (int i = 0; i < LINE_LIMIT - 3; i++) put(other_byte(8'hA5));
    put(8'hA5);
    put(8'h5A);
    put(8'hC3);
    put(8'h3C);
    put(8'hA5);
    end_line();
    put(8'hA5);
    end_line();
  endtask

  task automatic test_backpressure();
    logic [BYTE_W-1:0] sym;
    set_length(6'd2);
    sym = rand_byte();
    write_pat(0, sym);
    write_pat(1, ~sym);
    end_line();
    rx_hold_cycles = 80;
    no_gaps = 1'b1;
    for (int n = 0; n < 8; n++) begin
      repeat ($urandom_range(1, 6)) put($urandom_range(0, 1) ? sym : ~sym);
      end_line();
    end
    no_gaps = 1'b0;
    drain();
    repeat (3) put(~sym);
    put(sym);
    put(~sym);
    end_line();
  endtask

  task automatic test_random();
    int unsigned       start;
    int unsigned       pick;
    int unsigned       eff;
    int unsigned       llen;
    int                place;
    logic [CFG_W-1:0]  len;
    logic [BYTE_W-1:0] sym0;
    logic [BYTE_W-1:0] sym1;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      no_gaps = ($urandom_range(0, 5) == 0);
      pick = $urandom_range(0, 9);
      if (pick == 0)      len = '0;
      else if (pick <= 6) len = CFG_W'($urandom_range(1, 4));
      else if (pick <= 8) len = CFG_W'($urandom_range(5, 32));
      else                len = CFG_W'($urandom_range(33, 63));
      set_length(len);
      eff  = used_len();
      sym0 = rand_byte();
      sym1 = rand_byte();
      for (int i = 0; i < eff; i++) begin
        if ($urandom_range(0, 7) == 0) write_pat(i, rand_byte());
        else                           write_pat(i, $urandom_range(0, 1) ? sym1 : sym0);
      end
      repeat ($urandom_range(2, 6)) begin
        llen  = $urandom_range(0, 24) + eff;
        place = ($urandom_range(0, 2) == 0) ? -1 : int'($urandom_range(0, llen));
        for (int j = 0; j <= llen; j++) begin
          if (j == place) begin
            for (int k = 0; k < eff; k++) put(sw_pattern[k]);
          end
          if (j == llen) break;
          pick = $urandom_range(0, 59);
          if (pick == 0)      send_item(MODE_NONE, IDX_W'($urandom_range(0, 31)), rand_byte());
          else if (pick == 1) write_pat($urandom_range(0, 31), $urandom_range(0, 1) ? sym1 : sym0);
          else if (pick < 12) put(rand_byte());
          else                put($urandom_range(0, 1) ? sym1 : sym0);
        end
        end_line();
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    clear_line_state();
    repeat (9) @(negedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);
    test_empty_pattern();
    test_short_patterns();
    test_full_pattern();
    test_line_limit();
    test_backpressure();
    test_random();
    drain();
    if (pending_lines.size() != 0) error_count++;
    $display("Covered %0d input transactions and %0d line results, %0d cut at the limit.",
             items_sent, lines_checked, overflow_lines);
    $display("Pattern lengths from empty to above the store size, random gaps, long output stall.");
    if (error_count == 0) begin
      $display("tb_first_pattern_match_finder_top: done, clean");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("tb_first_pattern_match_finder_top: done, errors");
    end
    $finish;
  end

  initial begin
    #(64'd20_000_000);
    $display("timeout with %0d line results pending", pending_lines.size());
    $display("tb_first_pattern_match_finder_top: done, errors");
    $finish;
  end

endmodule
